>>> rtl/core/sbsc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sbsc_pkg
// shared constants and register codes for the segment box slab clipper
// ----------------------------------------------------------------------------
package sbsc_pkg;

    localparam int COORD_WIDTH_DEF     = 24;
    localparam int PARAM_FRAC_BITS_DEF = 16;
    localparam int TOL_W               = 16;
    localparam int CFG_IDX_W           = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DIR_TOL   = 2'd0,
        REG_PARAM_TOL = 2'd1
    } cfg_reg_t;

    localparam logic [TOL_W-1:0] DIR_TOL_RST   = 16'd1;
    localparam logic [TOL_W-1:0] PARAM_TOL_RST = 16'd1;

endpackage
`default_nettype wire

>>> rtl/core/sbsc_seg_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sbsc_seg_in_if
// segment and box transaction into the clipper
// ----------------------------------------------------------------------------
interface sbsc_seg_in_if
    import sbsc_pkg::*;
#(
    parameter int CW = COORD_WIDTH_DEF
);
    logic              valid;
    logic              ready;
    logic signed [CW-1:0] start_x;
    logic signed [CW-1:0] start_y;
    logic signed [CW-1:0] start_z;
    logic signed [CW-1:0] end_x;
    logic signed [CW-1:0] end_y;
    logic signed [CW-1:0] end_z;
    logic signed [CW-1:0] corner_a_x;
    logic signed [CW-1:0] corner_a_y;
    logic signed [CW-1:0] corner_a_z;
    logic signed [CW-1:0] corner_b_x;
    logic signed [CW-1:0] corner_b_y;
    logic signed [CW-1:0] corner_b_z;

    modport source (output valid, start_x, start_y, start_z, end_x, end_y, end_z,
                    corner_a_x, corner_a_y, corner_a_z, corner_b_x, corner_b_y,
                    corner_b_z, input ready);
    modport sink (input valid, start_x, start_y, start_z, end_x, end_y, end_z,
                  corner_a_x, corner_a_y, corner_a_z, corner_b_x, corner_b_y,
                  corner_b_z, output ready);
endinterface
`default_nettype wire

>>> rtl/core/sbsc_seg_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sbsc_seg_out_if
// clipped segment transaction out of the clipper
// ----------------------------------------------------------------------------
interface sbsc_seg_out_if
    import sbsc_pkg::*;
#(
    parameter int CW = COORD_WIDTH_DEF
);
    logic              valid;
    logic              ready;
    logic              hit;
    logic signed [CW-1:0] out_start_x;
    logic signed [CW-1:0] out_start_y;
    logic signed [CW-1:0] out_start_z;
    logic signed [CW-1:0] out_end_x;
    logic signed [CW-1:0] out_end_y;
    logic signed [CW-1:0] out_end_z;

    modport source (output valid, hit, out_start_x, out_start_y, out_start_z,
                    out_end_x, out_end_y, out_end_z, input ready);
    modport sink (input valid, hit, out_start_x, out_start_y, out_start_z,
                  out_end_x, out_end_y, out_end_z, output ready);
endinterface
`default_nettype wire

>>> rtl/core/sbsc_cfg_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sbsc_cfg_if
// register write channel
// ----------------------------------------------------------------------------
interface sbsc_cfg_if
    import sbsc_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [TOL_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

>>> rtl/core/sbsc_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sbsc_div
// pipelined restoring divider, one quotient bit per stage, saturated ratio
// ----------------------------------------------------------------------------
module sbsc_div
    import sbsc_pkg::*;
#(
    parameter int CW = COORD_WIDTH_DEF,
    parameter int PF = PARAM_FRAC_BITS_DEF
)
(
    input  wire logic                clk,
    input  wire logic                en,
    input  wire logic [CW:0]         num_mag,
    input  wire logic [CW:0]         den_mag,
    input  wire logic                neg,
    output logic signed [PF+2:0]     ratio
);
    localparam int QB = PF + 2;
    localparam int NW = CW + 1 + PF;
    localparam logic [QB-1:0] TSAT = QB'(1) << (PF + 1);

    logic [NW-1:0] rem_reg [QB+1];
    logic [CW:0]   den_reg [QB+1];
    logic [QB-1:0] q_reg   [QB+1];
    logic          ovf_reg [QB+1];
    logic          neg_reg [QB+1];
    logic signed [PF+2:0] ratio_reg;

    // entry: scale numerator, flag quotients of 4 or more
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= {num_mag, PF'(0)};
            den_reg[0] <= den_mag;
            q_reg[0]   <= '0;
            ovf_reg[0] <= ((CW+3)'(num_mag) >= {den_mag, 2'b00});
            neg_reg[0] <= neg;
        end
    end

    for (genvar j = 1; j <= QB; j++)
    begin : g_bit
        localparam int K = QB - j;
        logic [NW:0] dsh;
        logic [NW:0] remx;
        assign dsh  = (NW+1)'(den_reg[j-1]) << K;
        assign remx = {1'b0, rem_reg[j-1]};
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (remx >= dsh)
                begin
                    rem_reg[j] <= NW'(remx - dsh);
                    q_reg[j]   <= q_reg[j-1] | (QB'(1) << K);
                end
                else
                begin
                    rem_reg[j] <= rem_reg[j-1];
                    q_reg[j]   <= q_reg[j-1];
                end
                den_reg[j] <= den_reg[j-1];
                ovf_reg[j] <= ovf_reg[j-1];
                neg_reg[j] <= neg_reg[j-1];
            end
        end
    end

    logic [QB-1:0] mag;
    assign mag = (ovf_reg[QB] || (q_reg[QB] > TSAT)) ? TSAT : q_reg[QB];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ratio_reg <= neg_reg[QB] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
        end
    end

    assign ratio = ratio_reg;
endmodule
`default_nettype wire

>>> rtl/core/sbsc_point.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sbsc_point
// moves one coordinate along the segment: start + round(dir * t), or orig on a miss, two stages
// ----------------------------------------------------------------------------
module sbsc_point
    import sbsc_pkg::*;
#(
    parameter int CW = COORD_WIDTH_DEF,
    parameter int PF = PARAM_FRAC_BITS_DEF
)
(
    input  wire logic                 clk,
    input  wire logic                 en,
    input  wire logic                 hit,
    input  wire logic signed [CW-1:0] base,
    input  wire logic signed [CW-1:0] orig,
    input  wire logic signed [CW:0]   dir,
    input  wire logic signed [PF+2:0] t,
    output logic signed [CW-1:0]      res
);
    localparam int PW = CW + PF + 4;
    localparam logic signed [PW-1:0] HALF = PW'(1) << (PF - 1);

    logic signed [PW-1:0] prod_reg;
    logic signed [CW-1:0] base_reg;
    logic signed [CW-1:0] orig_reg;
    logic                 hit_reg;
    logic signed [CW-1:0] res_reg;
    logic signed [PW-1:0] rnd;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= PW'(dir) * PW'(t);
            base_reg <= base;
            orig_reg <= orig;
            hit_reg  <= hit;
        end
    end

    // round to nearest, ties upward
    assign rnd = (prod_reg + HALF) >>> PF;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_reg <= hit_reg ? CW'(base_reg + rnd[CW-1:0]) : orig_reg;
        end
    end

    assign res = res_reg;
endmodule
`default_nettype wire

>>> rtl/core/segment_box_slab_clipper_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// segment_box_slab_clipper_unit
// clips a 3d segment against an axis-aligned box by slab intersection
// ----------------------------------------------------------------------------
// The unit takes one segment per clock while the pipe is not held by
// backpressure and returns one clipped segment per transaction, in order.
// Most stages are in the six slab dividers, which produce one quotient bit
// per stage; the other six stages are input capture, the divider entry register
// that holds the prep results, the divider sign-and-saturate register,
// entry/exit combine, the multiply and the round-and-add output register. The
// whole pipe advances together whenever the output register is empty or being
// taken, so an empty output slot never holds up the input, and a full pipe
// holds still under backpressure. Both tolerance registers reset to 1 and are
// taken as static while items flow.
module segment_box_slab_clipper_unit
    import sbsc_pkg::*;
#(
    parameter int COORD_WIDTH     = COORD_WIDTH_DEF,
    parameter int PARAM_FRAC_BITS = PARAM_FRAC_BITS_DEF
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    sbsc_seg_in_if.sink   seg_in,
    sbsc_seg_out_if.source seg_out,
    sbsc_cfg_if.sink      cfg
);
    localparam int CW   = COORD_WIDTH;
    localparam int PF   = PARAM_FRAC_BITS;
    localparam int QB   = PF + 2;
    localparam int SL   = QB + 2;          // side line: prep through divider out
    localparam int D    = QB + 6;          // total valid stages
    localparam int CMPW = (CW + 1 > TOL_W) ? CW + 1 : TOL_W;
    localparam int TW   = PF + 3;
    localparam int TW2  = ((TW > TOL_W + 1) ? TW : TOL_W + 1) + 1;
    localparam logic signed [TW-1:0] T_ONE = TW'(1) << PF;

    // ---------------- configuration registers ----------------
    logic [TOL_W-1:0] dir_tol_reg;
    logic [TOL_W-1:0] par_tol_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dir_tol_reg <= DIR_TOL_RST;
            par_tol_reg <= PARAM_TOL_RST;
        end
        else if (cfg.valid)
        begin
            case (cfg_reg_t'(cfg.index))
                REG_DIR_TOL:   dir_tol_reg <= cfg.data;
                REG_PARAM_TOL: par_tol_reg <= cfg.data;
                default:       ;
            endcase
        end
    end

    // ---------------- pipe control ----------------
    logic [D-1:0] vld_reg;
    logic         en;

    // whole pipe moves when the output slot is free or being drained
    assign en           = !vld_reg[D-1] || seg_out.ready;
    assign seg_in.ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[D-2:0], seg_in.valid};
    end

    // ---------------- stage 0: capture transaction ----------------
    logic signed [CW-1:0] s_reg  [3];
    logic signed [CW-1:0] e_reg  [3];
    logic signed [CW-1:0] ca_reg [3];
    logic signed [CW-1:0] cb_reg [3];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s_reg[0]  <= seg_in.start_x;    s_reg[1]  <= seg_in.start_y;
            s_reg[2]  <= seg_in.start_z;
            e_reg[0]  <= seg_in.end_x;      e_reg[1]  <= seg_in.end_y;
            e_reg[2]  <= seg_in.end_z;
            ca_reg[0] <= seg_in.corner_a_x; ca_reg[1] <= seg_in.corner_a_y;
            ca_reg[2] <= seg_in.corner_a_z;
            cb_reg[0] <= seg_in.corner_b_x; cb_reg[1] <= seg_in.corner_b_y;
            cb_reg[2] <= seg_in.corner_b_z;
        end
    end

    // ---------------- prep: direction, slab numerators ----------------
    logic signed [CW:0] dir     [3];
    logic [CW:0]        dir_mag [3];
    logic [2:0]         ax_en;
    logic [CW:0]        n_mag   [6];
    logic               n_neg   [6];

    for (genvar i = 0; i < 3; i++)
    begin : g_prep
        logic signed [CW-1:0] lo;
        logic signed [CW-1:0] hi;
        logic signed [CW:0]   nh;
        logic signed [CW:0]   nl;
        assign lo = (ca_reg[i] < cb_reg[i]) ? ca_reg[i] : cb_reg[i];
        assign hi = (ca_reg[i] < cb_reg[i]) ? cb_reg[i] : ca_reg[i];
        assign dir[i]     = (CW+1)'(e_reg[i]) - (CW+1)'(s_reg[i]);
        assign dir_mag[i] = dir[i][CW] ? (CW+1)'(-dir[i]) : (CW+1)'(dir[i]);
        assign ax_en[i]   = CMPW'(dir_mag[i]) > CMPW'(dir_tol_reg);
        assign nh = (CW+1)'(hi) - (CW+1)'(s_reg[i]);
        assign nl = (CW+1)'(lo) - (CW+1)'(s_reg[i]);
        assign n_mag[2*i]   = nh[CW] ? (CW+1)'(-nh) : (CW+1)'(nh);
        assign n_mag[2*i+1] = nl[CW] ? (CW+1)'(-nl) : (CW+1)'(nl);
        assign n_neg[2*i]   = nh[CW] ^ dir[i][CW];
        assign n_neg[2*i+1] = nl[CW] ^ dir[i][CW];
    end

    // ---------------- six slab dividers ----------------
    logic signed [TW-1:0] rat [6];

    for (genvar k = 0; k < 6; k++)
    begin : g_div
        sbsc_div #(
            .CW (CW),
            .PF (PF)
        ) u_div (
            .clk     (clk),
            .en      (en),
            .num_mag (n_mag[k]),
            .den_mag (dir_mag[k/2]),
            .neg     (n_neg[k]),
            .ratio   (rat[k])
        );
    end

    // ---------------- side line alongside the dividers ----------------
    logic signed [CW-1:0] s_dl [SL][3];
    logic signed [CW-1:0] e_dl [SL][3];
    logic signed [CW:0]   d_dl [SL][3];
    logic [2:0]           ax_dl [SL];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s_dl[0]  <= s_reg;
            e_dl[0]  <= e_reg;
            d_dl[0]  <= dir;
            ax_dl[0] <= ax_en;
            for (int j = 1; j < SL; j++)
            begin
                s_dl[j]  <= s_dl[j-1];
                e_dl[j]  <= e_dl[j-1];
                d_dl[j]  <= d_dl[j-1];
                ax_dl[j] <= ax_dl[j-1];
            end
        end
    end

    // ---------------- combine: entry, exit and hit ----------------
    logic signed [TW-1:0]  tin;
    logic signed [TW-1:0]  tout;
    logic                  hit_c;

    always_comb
    begin
        logic signed [TW-1:0]  a;
        logic signed [TW-1:0]  b;
        logic signed [TW2-1:0] lim;
        tin  = '0;
        tout = T_ONE;
        for (int i = 0; i < 3; i++)
        begin
            a = (rat[2*i] < rat[2*i+1]) ? rat[2*i] : rat[2*i+1];
            b = (rat[2*i] < rat[2*i+1]) ? rat[2*i+1] : rat[2*i];
            if (ax_dl[SL-1][i])
            begin
                if (a > tin)
                    tin = a;
                if (b < tout)
                    tout = b;
            end
        end
        lim   = TW2'(tout) - $signed(TW2'(par_tol_reg));
        hit_c = !(TW2'(tin) >= lim);
    end

    logic signed [TW-1:0] tin_reg;
    logic signed [TW-1:0] tout_reg;
    logic                 hit_reg;
    logic signed [CW-1:0] s_c_reg [3];
    logic signed [CW-1:0] e_c_reg [3];
    logic signed [CW:0]   d_c_reg [3];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tin_reg  <= tin;
            tout_reg <= tout;
            hit_reg  <= hit_c;
            s_c_reg  <= s_dl[SL-1];
            e_c_reg  <= e_dl[SL-1];
            d_c_reg  <= d_dl[SL-1];
        end
    end

    // ---------------- multiply, round and add ----------------
    logic signed [CW-1:0] p_start [3];
    logic signed [CW-1:0] p_end   [3];
    logic                 hit_p_reg;
    logic                 hit_o_reg;

    for (genvar i = 0; i < 3; i++)
    begin : g_pt
        sbsc_point #(
            .CW (CW),
            .PF (PF)
        ) u_start (
            .clk  (clk),
            .en   (en),
            .hit  (hit_reg),
            .base (s_c_reg[i]),
            .orig (s_c_reg[i]),
            .dir  (d_c_reg[i]),
            .t    (tin_reg),
            .res  (p_start[i])
        );
        sbsc_point #(
            .CW (CW),
            .PF (PF)
        ) u_end (
            .clk  (clk),
            .en   (en),
            .hit  (hit_reg),
            .base (s_c_reg[i]),
            .orig (e_c_reg[i]),
            .dir  (d_c_reg[i]),
            .t    (tout_reg),
            .res  (p_end[i])
        );
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hit_p_reg <= hit_reg;
            hit_o_reg <= hit_p_reg;
        end
    end

    // ---------------- output transaction ----------------
    assign seg_out.valid       = vld_reg[D-1];
    assign seg_out.hit         = hit_o_reg;
    assign seg_out.out_start_x = p_start[0];
    assign seg_out.out_start_y = p_start[1];
    assign seg_out.out_start_z = p_start[2];
    assign seg_out.out_end_x   = p_end[0];
    assign seg_out.out_end_y   = p_end[1];
    assign seg_out.out_end_z   = p_end[2];

    // ---------------- assertions ----------------
    // a held pipe keeps every valid bit in place
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(vld_reg))
        else $error("valid bits moved while the pipe was held");

    // an accepted transaction enters the first stage
    a_accept_enter: assert property (@(posedge clk) disable iff (!rst_n)
        (seg_in.valid && seg_in.ready) |=> vld_reg[0])
        else $error("accepted transaction not captured");

    // a finished result is only dropped by being taken
    a_out_kept: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg[D-1] && !seg_out.ready) |=> (vld_reg[D-1] && $stable(hit_o_reg)))
        else $error("stalled result lost");
endmodule
`default_nettype wire
